@@ hdl/mbs_pkg.sv @@
// Shared types and constants for the mean background subtraction core.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps
`default_nettype none

package mbs_pkg;

   localparam int LEARN_FRAMES_DEF = 20;
   localparam int STORE_DEPTH_DEF  = 65536;

   localparam int PIX_W      = 8;
   localparam int THR_W      = 8;
   localparam int PPF_W      = 17;
   localparam int SUM_W      = 13;             // per-pixel sum, wraps
   localparam int NUM_W      = SUM_W + 1;      // sum plus rounding half
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [THR_W-1:0] THR_RESET = 8'd50;
   localparam int               PPF_RESET = 65536;
   localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIFF_THRESHOLD   = 2'd0,
      CSR_PIXELS_PER_FRAME = 2'd1
   } csr_index_type;

   // Per-item control that rides the pipeline.
   typedef struct packed {
      logic valid;
      logic learn;   // 1: accumulate, 0: subtract
   } mbs_op_type;

endpackage

`default_nettype wire

@@ hdl/mbs_frame_seq.sv @@
// Pixel position and frame counters, frame length register.
// Depends on mbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbs_frame_seq #(
   parameter int LEARN_FRAMES = mbs_pkg::LEARN_FRAMES_DEF,
   parameter int STORE_DEPTH  = mbs_pkg::STORE_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic                           len_we,
   input  wire logic [mbs_pkg::PPF_W-1:0]      len_data,
   output logic [$clog2(STORE_DEPTH)-1:0]      pos,
   output mbs_pkg::mbs_op_type                 op
);

   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int FRAME_W = $clog2(LEARN_FRAMES + 2);
   localparam int CMP_W   = (ADDR_W + 1 > mbs_pkg::PPF_W) ? ADDR_W + 1 : mbs_pkg::PPF_W;
   localparam int LEN_RESET = (mbs_pkg::PPF_RESET > STORE_DEPTH) ?
                              STORE_DEPTH : mbs_pkg::PPF_RESET;
   localparam logic [ADDR_W-1:0]  LEN_M1_RESET = ADDR_W'(LEN_RESET - 1);
   localparam logic [FRAME_W-1:0] LEARN_END    = FRAME_W'(LEARN_FRAMES);
   localparam logic [FRAME_W-1:0] FRAME_SAT    = FRAME_W'(LEARN_FRAMES + 1);

   logic [ADDR_W-1:0]  len_m1_ff, len_m1_in;
   logic [ADDR_W-1:0]  position_ff, position_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [CMP_W-1:0]   req_len;
   logic               last;

   // Frame length clamp: zero acts as one, capped at store depth.
   always_comb begin
      req_len = CMP_W'(len_data);
      if (req_len == '0) begin
         req_len = CMP_W'(1);
      end else if (req_len > CMP_W'(STORE_DEPTH)) begin
         req_len = CMP_W'(STORE_DEPTH);
      end
      len_m1_in = len_we ? ADDR_W'(req_len - CMP_W'(1)) : len_m1_ff;
   end

   assign pos  = (position_ff > len_m1_ff) ? len_m1_ff : position_ff;
   assign last = (pos == len_m1_ff);

   always_comb begin
      position_in = position_ff;
      frame_in    = frame_ff;
      if (accept) begin
         position_in = last ? '0 : pos + ADDR_W'(1);
         if (last && frame_ff != FRAME_SAT) begin
            frame_in = frame_ff + FRAME_W'(1);
         end
      end
   end

   assign op.learn = (frame_ff < LEARN_END);
   assign op.valid = (frame_ff < LEARN_END) || (frame_ff > LEARN_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_m1_ff   <= LEN_M1_RESET;
         position_ff <= '0;
         frame_ff    <= '0;
      end else begin
         len_m1_ff   <= len_m1_in;
         position_ff <= position_in;
         frame_ff    <= frame_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/mbs_accum_store.sv @@
// Per-pixel sum memory with read-modify-write pipeline and forwarding.
// Depends on mbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbs_accum_store #(
   parameter int LEARN_FRAMES = mbs_pkg::LEARN_FRAMES_DEF,
   parameter int STORE_DEPTH  = mbs_pkg::STORE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire mbs_pkg::mbs_op_type           in_op,
   input  wire logic [$clog2(STORE_DEPTH)-1:0] in_pos,
   input  wire logic [mbs_pkg::PIX_W-1:0]     in_pixel,
   output mbs_pkg::mbs_op_type                out_op,
   output logic [mbs_pkg::NUM_W-1:0]          out_num,
   output logic [mbs_pkg::PIX_W-1:0]          out_pixel
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int SUM_W  = mbs_pkg::SUM_W;
   localparam int NUM_W  = mbs_pkg::NUM_W;
   localparam logic [NUM_W-1:0] HALF = NUM_W'(LEARN_FRAMES / 2);

   logic [SUM_W-1:0] sum_mem [STORE_DEPTH];
   logic [SUM_W-1:0] rd_ff;

   // Entries at or above the fill count were never written since reset.
   logic [ADDR_W:0] fill_ff, fill_in;

   mbs_pkg::mbs_op_type     s1_op_ff, s2_op_ff;
   logic [ADDR_W-1:0]       s1_pos_ff, s2_pos_ff;
   logic [mbs_pkg::PIX_W-1:0] s1_pix_ff, s2_pix_ff;
   logic [SUM_W-1:0]        s2_sum_ff;
   logic [NUM_W-1:0]        s2_num_ff;

   logic [SUM_W-1:0] base;
   logic [SUM_W-1:0] sum_new;
   logic             wr_en;

   always_comb begin
      if (s2_op_ff.valid && s2_op_ff.learn && s2_pos_ff == s1_pos_ff) begin
         base = s2_sum_ff;                 // write landed on our read edge
      end else if ({1'b0, s1_pos_ff} < fill_ff) begin
         base = rd_ff;
      end else begin
         base = '0;
      end
      sum_new = base + SUM_W'(s1_pix_ff);
      wr_en   = en && s1_op_ff.valid && s1_op_ff.learn;
      fill_in = fill_ff;
      if (wr_en && {1'b0, s1_pos_ff} == fill_ff) begin
         fill_in = fill_ff + (ADDR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[s1_pos_ff] <= sum_new;
      end
      if (in_op.valid) begin
         rd_ff <= sum_mem[in_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         s1_op_ff <= '0;
         s2_op_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (en) begin
            s1_op_ff <= in_op;
            s2_op_ff <= s1_op_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pos_ff <= in_pos;
         s1_pix_ff <= in_pixel;
         s2_pos_ff <= s1_pos_ff;
         s2_pix_ff <= s1_pix_ff;
         s2_sum_ff <= sum_new;
         s2_num_ff <= NUM_W'(base) + HALF;
      end
   end

   assign out_op.valid = s2_op_ff.valid && !s2_op_ff.learn;
   assign out_op.learn = s2_op_ff.learn;
   assign out_num      = s2_num_ff;
   assign out_pixel    = s2_pix_ff;

endmodule

`default_nettype wire

@@ hdl/mbs_mean_diff.sv @@
// Mean by reciprocal multiply, clamp, absolute difference and threshold.
// Depends on mbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbs_mean_diff #(
   parameter int LEARN_FRAMES = mbs_pkg::LEARN_FRAMES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire mbs_pkg::mbs_op_type       in_op,
   input  wire logic [mbs_pkg::NUM_W-1:0] in_num,
   input  wire logic [mbs_pkg::PIX_W-1:0] in_pixel,
   input  wire logic [mbs_pkg::THR_W-1:0] threshold,
   output logic                           out_valid,
   output logic [mbs_pkg::PIX_W-1:0]      out_difference,
   output logic                           out_foreground
);

   localparam int NUM_W  = mbs_pkg::NUM_W;
   localparam int PIX_W  = mbs_pkg::PIX_W;
   // floor(n / LEARN_FRAMES) == (n * RECIP) >> SHIFT for every n below 2**NUM_W
   localparam int SHIFT  = NUM_W + $clog2(LEARN_FRAMES);
   localparam int RECIP  = ((1 << SHIFT) + LEARN_FRAMES - 1) / LEARN_FRAMES;
   localparam int RECIP_W = NUM_W + 2;
   localparam int PROD_W = SHIFT + NUM_W;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

   logic [PROD_W-1:0] prod;
   logic              s3_valid_ff;
   logic [NUM_W-1:0]  s3_quot_ff;
   logic [PIX_W-1:0]  s3_pix_ff;
   logic [PIX_W-1:0]  mean;
   logic [PIX_W-1:0]  diff;

   logic              valid_ff;
   logic [PIX_W-1:0]  diff_ff;
   logic              fg_ff;

   assign prod = PROD_W'(in_num) * PROD_W'(RECIP_C);

   always_comb begin
      mean = (s3_quot_ff > NUM_W'(mbs_pkg::PIX_MAX)) ? mbs_pkg::PIX_MAX
                                                       : s3_quot_ff[PIX_W-1:0];
      diff = (s3_pix_ff >= mean) ? s3_pix_ff - mean : mean - s3_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= in_op.valid;
         valid_ff    <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_quot_ff <= prod[SHIFT +: NUM_W];
         s3_pix_ff  <= in_pixel;
         diff_ff    <= diff;
         fg_ff      <= (diff > threshold);
      end
   end

   assign out_valid      = valid_ff;
   assign out_difference = diff_ff;
   assign out_foreground = fg_ff;

endmodule

`default_nettype wire

@@ hdl/mean_background_subtract_core.sv @@
// Top level of the frame-averaging background subtraction core.
// Depends on mbs_pkg, mbs_frame_seq, mbs_accum_store, mbs_mean_diff.
//
// Usage:
//  - req_ channel: one gray pixel per transaction, raster order. The core
//    tracks pixel position and frame number on its own.
//  - rsp_ channel: no transactions during the learning frames and the frame
//    after them; afterwards one transaction per pixel with |pixel - mean|
//    and the foreground flag (difference above threshold).
//  - csr_ channel: index 0 threshold, index 1 pixels per frame; other
//    indexes are dropped. Always ready. Write only while the core is idle.
//  - Throughput: one pixel per clock while rsp_ is not stalled. A result
//    is registered on rsp_ once its pixel has passed s1, s2, s3 and the
//    output register. The sum memory (one read port, one write port) sets
//    the steps: read, add/write back, multiply, difference, output register.
//  - Stall: while an rsp_ transaction waits under rsp_stall, the whole
//    pipeline holds and req_stall is raised; nothing is lost or repeated.
//  - Reset: counters, threshold and frame length return to defaults. The
//    sum memory is not swept; a fill count marks written entries and the
//    rest read as zero, so the core is ready on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module mean_background_subtract_core #(
   parameter int LEARN_FRAMES = mbs_pkg::LEARN_FRAMES_DEF,
   parameter int STORE_DEPTH  = mbs_pkg::STORE_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // pixel input
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [mbs_pkg::PIX_W-1:0]      req_pixel,
   // result output
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [mbs_pkg::PIX_W-1:0]           rsp_difference,
   output logic                                rsp_foreground,
   // register writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mbs_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);

   logic                         en;
   logic                         accept;
   logic                         csr_write;
   logic                         len_we;
   logic [mbs_pkg::THR_W-1:0]    thr_ff, thr_in;

   logic [ADDR_W-1:0]            seq_pos;
   mbs_pkg::mbs_op_type          seq_op;
   mbs_pkg::mbs_op_type          acc_in_op;
   mbs_pkg::mbs_op_type          acc_out_op;
   logic [mbs_pkg::NUM_W-1:0]    acc_num;
   logic [mbs_pkg::PIX_W-1:0]    acc_pixel;

   // Pipeline advances unless a finished result sits stalled at the output.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // Register writes
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign len_we    = csr_write && (csr_index == mbs_pkg::CSR_PIXELS_PER_FRAME);
   assign thr_in    = (csr_write && csr_index == mbs_pkg::CSR_DIFF_THRESHOLD) ?
                      csr_data[mbs_pkg::THR_W-1:0] : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mbs_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // Position/frame bookkeeping; skipped-frame pixels carry no valid bit.
   mbs_frame_seq #(
      .LEARN_FRAMES (LEARN_FRAMES),
      .STORE_DEPTH  (STORE_DEPTH)
   ) u_frame_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .len_we   (len_we),
      .len_data (csr_data[mbs_pkg::PPF_W-1:0]),
      .pos      (seq_pos),
      .op       (seq_op)
   );

   assign acc_in_op.valid = seq_op.valid && accept;
   assign acc_in_op.learn = seq_op.learn;

   // Stages 1-2: memory read, accumulate / write back, rounding add.
   mbs_accum_store #(
      .LEARN_FRAMES (LEARN_FRAMES),
      .STORE_DEPTH  (STORE_DEPTH)
   ) u_accum_store (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_op     (acc_in_op),
      .in_pos    (seq_pos),
      .in_pixel  (req_pixel),
      .out_op    (acc_out_op),
      .out_num   (acc_num),
      .out_pixel (acc_pixel)
   );

   // Stages 3-4: divide by frame count, difference, output register.
   mbs_mean_diff #(
      .LEARN_FRAMES (LEARN_FRAMES)
   ) u_mean_diff (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_op          (acc_out_op),
      .in_num         (acc_num),
      .in_pixel       (acc_pixel),
      .threshold      (thr_ff),
      .out_valid      (rsp_valid),
      .out_difference (rsp_difference),
      .out_foreground (rsp_foreground)
   );

endmodule

`default_nettype wire
